### rtl/rth_pkg.sv
package rth_pkg;

	localparam int DIV_STEPS = 12;

	localparam logic [14:0] HUE_GREEN_BASE = 15'd7680;
	localparam logic [14:0] HUE_BLUE_BASE  = 15'd15360;
	localparam logic [14:0] HUE_CIRCLE     = 15'd23040;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [14:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
	} hsv_t;

	typedef enum logic [2:0] {
		SEC_RED   = 3'b001,
		SEC_GREEN = 3'b010,
		SEC_BLUE  = 3'b100
	} sector_t;

	// partial remainder and dividend bits that turn into quotient bits
	typedef struct packed {
		logic [7:0]           rem;
		logic [DIV_STEPS-1:0] nq;
	} div_t;

	typedef struct packed {
		logic [7:0] mx;
		logic [7:0] delta;
		sector_t    sector;
		logic       neg;
		logic       gray;
		div_t       hue_div;
		div_t       sat_div;
	} work_t;

	// one restoring step: remainder stays below the divisor
	function automatic div_t div_step(div_t cur, logic [7:0] divisor);
		logic [8:0] trial;
		logic       fit;
		div_t       nxt;
		trial   = {cur.rem, cur.nq[DIV_STEPS-1]};
		fit     = (trial >= {1'b0, divisor});
		nxt.rem = fit ? 8'(trial - {1'b0, divisor}) : trial[7:0];
		nxt.nq  = {cur.nq[DIV_STEPS-2:0], fit};
		return nxt;
	endfunction

endpackage

### rtl/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter. Takes one 8-bit RGB pixel per clock unless hsv_ready
// stalls the output, and returns hue in 1/64-degree units (0..23039), saturation as
// delta*255/max truncated, and brightness as the largest channel; gray pixels give hue
// 0 and saturation 0. From pixel request to hsv request there is one stage for max/min
// and sector select, one for the numerators, twelve for the bit-per-stage restoring
// dividers that run hue and saturation side by side, and the output register. Each
// stage holds its item under backpressure, so a stall drops nothing.
module rgb_to_hsv_converter
	import rth_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pixel_valid,
	output logic pixel_ready,
	input  rgb_t pixel,
	output logic hsv_valid,
	input  logic hsv_ready,
	output hsv_t hsv
);

	typedef struct packed {
		logic [7:0]        mx;
		logic [7:0]        mn;
		sector_t           sector;
		logic signed [8:0] diff;
	} front_t;

	front_t front_next;
	front_t front_s1;
	logic   valid_s1;
	logic   ready_s1;

	work_t  prep_next;
	work_t  prep_s2;
	logic   valid_s2;
	logic   ready_s2;

	logic [DIV_STEPS:0] div_valid;
	logic [DIV_STEPS:0] div_ready;
	work_t              div_work [DIV_STEPS+1];

	hsv_t   res_next;
	hsv_t   res_s15;
	logic   valid_s15;
	logic   ready_s15;

	// stage 1: max, min and sector
	always_comb begin
		logic [7:0] min_rg;
		min_rg = (pixel.red < pixel.green) ? pixel.red : pixel.green;
		front_next.mn = (min_rg < pixel.blue) ? min_rg : pixel.blue;
		if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
			front_next.sector = SEC_RED;
			front_next.mx     = pixel.red;
			front_next.diff   = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
		end else if (pixel.green >= pixel.blue) begin
			front_next.sector = SEC_GREEN;
			front_next.mx     = pixel.green;
			front_next.diff   = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
		end else begin
			front_next.sector = SEC_BLUE;
			front_next.mx     = pixel.blue;
			front_next.diff   = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
		end
	end

	assign ready_s1    = !valid_s1 || ready_s2;
	assign pixel_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_valid && ready_s1) begin
			front_s1 <= front_next;
		end
	end

	// stage 2: delta and dividends
	always_comb begin
		logic [7:0]  mag;
		logic [19:0] hue_num;
		logic [15:0] sat_num;
		mag     = front_s1.diff[8] ? 8'(-front_s1.diff) : front_s1.diff[7:0];
		hue_num = {mag, 12'b0} - {4'b0, mag, 8'b0};
		prep_next.mx     = front_s1.mx;
		prep_next.delta  = front_s1.mx - front_s1.mn;
		prep_next.sector = front_s1.sector;
		prep_next.neg    = front_s1.diff[8];
		prep_next.gray   = (front_s1.mx == front_s1.mn);
		sat_num = {prep_next.delta, 8'b0} - {8'b0, prep_next.delta};
		prep_next.hue_div.rem = hue_num[19:12];
		prep_next.hue_div.nq  = hue_num[11:0];
		prep_next.sat_div.rem = {4'b0, sat_num[15:12]};
		prep_next.sat_div.nq  = sat_num[11:0];
	end

	assign ready_s2 = !valid_s2 || div_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			prep_s2 <= prep_next;
		end
	end

	// divider stages
	assign div_valid[0] = valid_s2;
	assign div_work[0]  = prep_s2;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		rth_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[i]),
			.in_ready  (div_ready[i]),
			.in_work   (div_work[i]),
			.out_valid (div_valid[i+1]),
			.out_ready (div_ready[i+1]),
			.out_work  (div_work[i+1])
		);
	end

	// output stage: sector offset and sign fix
	always_comb begin
		work_t       w;
		logic [14:0] base;
		logic [14:0] q;
		logic [14:0] q_up;
		w    = div_work[DIV_STEPS];
		q    = {3'b0, w.hue_div.nq};
		q_up = q + {14'b0, (w.hue_div.rem != 8'd0)};
		case (w.sector)
			SEC_RED:   base = w.neg ? HUE_CIRCLE : 15'd0;
			SEC_GREEN: base = HUE_GREEN_BASE;
			SEC_BLUE:  base = HUE_BLUE_BASE;
			default:   base = 15'd0;
		endcase
		res_next.brightness = w.mx;
		if (w.gray) begin
			res_next.hue        = 15'd0;
			res_next.saturation = 8'd0;
		end else begin
			res_next.hue        = w.neg ? (base - q_up) : (base + q);
			res_next.saturation = w.sat_div.nq[7:0];
		end
	end

	assign ready_s15            = !valid_s15 || hsv_ready;
	assign div_ready[DIV_STEPS] = ready_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s15 <= 1'b0;
		end else if (ready_s15) begin
			valid_s15 <= div_valid[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (div_valid[DIV_STEPS] && ready_s15) begin
			res_s15 <= res_next;
		end
	end

	assign hsv_valid = valid_s15;
	assign hsv       = res_s15;

endmodule

### rtl/rth_div_stage.sv
module rth_div_stage
	import rth_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  work_t in_work,
	output logic  out_valid,
	input  logic  out_ready,
	output work_t out_work
);

	logic  valid_s1;
	work_t work_s1;
	work_t step_work;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		step_work         = in_work;
		step_work.hue_div = div_step(in_work.hue_div, in_work.delta);
		step_work.sat_div = div_step(in_work.sat_div, in_work.mx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			work_s1 <= step_work;
		end
	end

	assign out_valid = valid_s1;
	assign out_work  = work_s1;

endmodule

### rtl/rth_checker.sv
module rth_checker
	import rth_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic pixel_valid,
	input logic pixel_ready,
	input logic hsv_valid,
	input logic hsv_ready,
	input hsv_t hsv
);

	logic [3:0] inflight_q;
	logic       pix_acc;
	logic       hsv_acc;

	assign pix_acc = pixel_valid && pixel_ready;
	assign hsv_acc = hsv_valid && hsv_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 4'd0;
		end else if (pix_acc && !hsv_acc) begin
			inflight_q <= inflight_q + 4'd1;
		end else if (!pix_acc && hsv_acc) begin
			inflight_q <= inflight_q - 4'd1;
		end
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> inflight_q != 4'd0)
		else $error("hsv request with no pixel in flight");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == 4'd15 && !hsv_ready) |-> !pixel_ready)
		else $error("pixel taken while pipeline full and stalled");

	a_hsv_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && !hsv_ready) |=> (hsv_valid && $stable(hsv)))
		else $error("stalled hsv request changed");

	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv.saturation == 8'd0) |-> (hsv.hue == 15'd0))
		else $error("gray pixel with nonzero hue");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hsv.hue < HUE_CIRCLE)
		else $error("hue out of range");

endmodule

bind rgb_to_hsv_converter rth_checker u_rth_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel_valid),
	.pixel_ready (pixel_ready),
	.hsv_valid   (hsv_valid),
	.hsv_ready   (hsv_ready),
	.hsv         (hsv)
);
